// ----- hw/rtl/gha_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gha_pkg
// Shared codes and control types for the generational handle allocator:
// request codes, result status codes and the controller/datapath signals.
// ----------------------------------------------------------------------------
package gha_pkg;

	// request codes on func
	localparam logic [1:0] FUNC_CREATE  = 2'd0;
	localparam logic [1:0] FUNC_DESTROY = 2'd1;
	localparam logic [1:0] FUNC_QUERY   = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_STALE = 2'd2;

	// reset value of the reuse threshold register
	localparam int unsigned MIN_FREE_RESET = 64;

	// controller to datapath
	typedef struct packed {
		logic accept;  // capture the request
		logic pop_rd;  // read the free queue at its head
		logic gen_rd;  // read the generation table
		logic exec;    // update state and register the result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_pop;  // request is a create that reuses a freed index
	} stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gha_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gha_ctrl
// Sequencer for one request: optional free queue read, generation table
// read, then execute. Drives busy and the datapath commands.
// ----------------------------------------------------------------------------
module gha_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire gha_pkg::stat_t stat,
	output gha_pkg::cmd_t      cmd,
	output logic               busy
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_LOOKUP,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_comb begin
		cmd.accept = start & ~busy_q;
		cmd.pop_rd = (state_q == S_POP);
		cmd.gen_rd = (state_q == S_LOOKUP);
		cmd.exec   = (state_q == S_EXEC);
	end

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						busy_q  <= 1'b1;
						state_q <= stat.need_pop ? S_POP : S_LOOKUP;
					end
				end
				S_POP: begin
					state_q <= S_LOOKUP;
				end
				S_LOOKUP: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					busy_q  <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					busy_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> busy_q)
		else $error("busy not raised after a request transfer");
	a_exec_release: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> (!busy_q && state_q == S_IDLE))
		else $error("controller did not release after execute");
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.pop_rd, cmd.gen_rd, cmd.exec}) && (busy_q == (state_q != S_IDLE)))
		else $error("controller commands or busy inconsistent with state");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/gha_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gha_dpath
// Generation table, free index queue, counters, threshold register and
// result registers of the handle allocator.
// ----------------------------------------------------------------------------
module gha_dpath #(
	parameter int INDEX_BITS = 10,
	parameter int GEN_BITS   = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire gha_pkg::cmd_t         cmd,
	output gha_pkg::stat_t             stat,
	input  wire logic                  cfg_we,
	input  wire logic [INDEX_BITS:0]   cfg_wdata,
	input  wire logic [1:0]            func,
	input  wire logic [INDEX_BITS-1:0] handle_index,
	input  wire logic [GEN_BITS-1:0]   handle_generation,
	output logic                       done,
	output logic [1:0]                 status,
	output logic                       is_alive,
	output logic [INDEX_BITS-1:0]      out_index,
	output logic [GEN_BITS-1:0]        out_generation
);

	localparam int DEPTH = 1 << INDEX_BITS;

	// storage
	logic [GEN_BITS-1:0]   gen_mem [DEPTH];
	logic [INDEX_BITS-1:0] fifo_mem [DEPTH];

	// control state
	logic [INDEX_BITS-1:0] head_q, tail_q;
	logic [INDEX_BITS:0]   count_q, fresh_q, min_free_q;

	// captured request
	logic [1:0]            func_q;
	logic [INDEX_BITS-1:0] idx_q;
	logic [GEN_BITS-1:0]   gen_q;
	logic                  reuse_q;

	// read data
	logic [INDEX_BITS-1:0] fifo_rd_q;
	logic [GEN_BITS-1:0]   gen_rd_q;

	// result registers
	logic                  done_q;
	logic [1:0]            status_q;
	logic                  alive_q;
	logic [INDEX_BITS-1:0] oidx_q;
	logic [GEN_BITS-1:0]   ogen_q;

	// execute decode
	logic                  alive;
	logic                  fresh_avail;
	logic                  fifo_full;
	logic                  do_reuse, do_fresh, do_free;
	logic                  gen_we;
	logic [INDEX_BITS-1:0] gen_waddr, gen_raddr;
	logic [GEN_BITS-1:0]   gen_wdata;

	assign stat.need_pop = (func == gha_pkg::FUNC_CREATE) && (count_q > min_free_q);

	assign alive       = ({1'b0, idx_q} < fresh_q) && (gen_rd_q == gen_q);
	assign fresh_avail = ~fresh_q[INDEX_BITS];
	assign fifo_full   = count_q[INDEX_BITS];

	assign do_reuse = cmd.exec && (func_q == gha_pkg::FUNC_CREATE) && reuse_q;
	assign do_fresh = cmd.exec && (func_q == gha_pkg::FUNC_CREATE) && !reuse_q && fresh_avail;
	assign do_free  = cmd.exec && (func_q == gha_pkg::FUNC_DESTROY) && alive && !fifo_full;

	assign gen_we    = do_fresh | do_free;
	assign gen_waddr = do_fresh ? fresh_q[INDEX_BITS-1:0] : idx_q;
	assign gen_wdata = do_fresh ? '0 : GEN_BITS'(gen_rd_q + 1'b1);
	assign gen_raddr = reuse_q ? fifo_rd_q : idx_q;

	// generation table
	always_ff @(posedge clk) begin
		if (gen_we) begin
			gen_mem[gen_waddr] <= gen_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.gen_rd) begin
			gen_rd_q <= gen_mem[gen_raddr];
		end
	end

	// free index queue
	always_ff @(posedge clk) begin
		if (do_free) begin
			fifo_mem[tail_q] <= idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop_rd) begin
			fifo_rd_q <= fifo_mem[head_q];
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q  <= func;
			idx_q   <= handle_index;
			gen_q   <= handle_generation;
			reuse_q <= stat.need_pop;
		end
	end

	// counters and threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			fresh_q    <= '0;
			min_free_q <= (INDEX_BITS+1)'(gha_pkg::MIN_FREE_RESET);
		end else begin
			if (cfg_we) begin
				min_free_q <= cfg_wdata;
			end
			if (do_reuse) begin
				head_q  <= head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
			if (do_fresh) begin
				fresh_q <= fresh_q + 1'b1;
			end
			if (do_free) begin
				tail_q  <= tail_q + 1'b1;
				count_q <= count_q + 1'b1;
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= gha_pkg::ST_OK;
			alive_q  <= 1'b0;
			oidx_q   <= '0;
			ogen_q   <= '0;
			case (func_q)
				gha_pkg::FUNC_CREATE: begin
					if (reuse_q) begin
						oidx_q <= fifo_rd_q;
						ogen_q <= gen_rd_q;
					end else if (fresh_avail) begin
						oidx_q <= fresh_q[INDEX_BITS-1:0];
					end else begin
						status_q <= gha_pkg::ST_FULL;
					end
				end
				gha_pkg::FUNC_DESTROY: begin
					if (!alive) begin
						status_q <= gha_pkg::ST_STALE;
					end else if (fifo_full) begin
						status_q <= gha_pkg::ST_FULL;
					end
				end
				gha_pkg::FUNC_QUERY: begin
					alive_q <= alive;
				end
				default: begin
					status_q <= gha_pkg::ST_OK;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign is_alive       = alive_q;
	assign out_index      = oidx_q;
	assign out_generation = ogen_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= (INDEX_BITS+1)'(DEPTH)) && (fresh_q <= (INDEX_BITS+1)'(DEPTH)))
		else $error("free count or fresh index beyond table depth");
	a_queue_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[INDEX_BITS-1:0] == INDEX_BITS'(tail_q - head_q))
		else $error("free queue pointers disagree with free count");
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/generational_handle_allocator_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_allocator_core
// Hands out index/generation handles, retires them through a queue of freed
// indices and answers liveness queries.
//
//   channel   ports                                          direction
//   request   start, func, handle_index, handle_generation   in  (busy)
//   result    done, status, is_alive, out_index, out_generation  out
//   config    cfg_we, cfg_wdata (reuse threshold)            in
//
// A request is taken when start is high and busy is low. A create that
// reuses a freed index runs a queue read, a table read and execute, each
// memory behind one registered port; other requests skip the queue read.
// Busy holds off the next request until execute ends. The result shows
// for one cycle with done, in the cycle busy falls; it cannot be stalled.
// Reset sets counters, pointers, control state; tables need no clearing.
// ----------------------------------------------------------------------------
module generational_handle_allocator_core #(
	parameter int INDEX_BITS = 10,
	parameter int GEN_BITS   = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            func,
	input  wire logic [INDEX_BITS-1:0] handle_index,
	input  wire logic [GEN_BITS-1:0]   handle_generation,
	output logic                       done,
	output logic [1:0]                 status,
	output logic                       is_alive,
	output logic [INDEX_BITS-1:0]      out_index,
	output logic [GEN_BITS-1:0]        out_generation,
	input  wire logic                  cfg_we,
	input  wire logic [INDEX_BITS:0]   cfg_wdata
);

	gha_pkg::cmd_t  cmd;
	gha_pkg::stat_t stat;

	gha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	gha_dpath #(
		.INDEX_BITS (INDEX_BITS),
		.GEN_BITS   (GEN_BITS)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.func              (func),
		.handle_index      (handle_index),
		.handle_generation (handle_generation),
		.done              (done),
		.status            (status),
		.is_alive          (is_alive),
		.out_index         (out_index),
		.out_generation    (out_generation)
	);

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for generational_handle_allocator_core. Requests come
// from a queue drained by a clocked driver; a clocked monitor predicts every
// accepted request against its own copy of the allocator state and checks
// each result, field by field, in order. The run walks several reuse
// thresholds, exhausts the fresh indices and fills the free queue.
// ----------------------------------------------------------------------------
module tb;

	localparam int IDX_W = 10;
	localparam int GEN_W = 8;
	localparam int SLOTS = 1 << IDX_W;
	localparam logic [1:0] FUNC_NOP = 2'd3;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [1:0]       func;
		logic [IDX_W-1:0] idx;
		logic [GEN_W-1:0] gen;
		int unsigned      gap;
	} request_t;

	typedef struct {
		logic [1:0]       status;
		logic             alive;
		logic [IDX_W-1:0] idx;
		logic [GEN_W-1:0] gen;
	} outcome_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [1:0]       func = gha_pkg::FUNC_CREATE;
	logic [IDX_W-1:0] handle_index = '0;
	logic [GEN_W-1:0] handle_generation = '0;
	logic             cfg_we = 1'b0;
	logic [IDX_W:0]   cfg_wdata = '0;
	logic             busy;
	logic             done;
	logic [1:0]       status;
	logic             is_alive;
	logic [IDX_W-1:0] out_index;
	logic [GEN_W-1:0] out_generation;

	generational_handle_allocator_core #(
		.INDEX_BITS(IDX_W),
		.GEN_BITS  (GEN_W)
	) uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.func             (func),
		.handle_index     (handle_index),
		.handle_generation(handle_generation),
		.done             (done),
		.status           (status),
		.is_alive         (is_alive),
		.out_index        (out_index),
		.out_generation   (out_generation),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata)
	);

	// predicted allocator state
	logic [GEN_W-1:0] gen_mem [SLOTS];
	logic [IDX_W-1:0] free_ring [SLOTS];
	logic [IDX_W-1:0] ring_head = '0;
	logic [IDX_W-1:0] ring_tail = '0;
	logic [IDX_W:0]   ring_count = '0;
	logic [IDX_W:0]   next_fresh = '0;
	logic [IDX_W:0]   reuse_min = (IDX_W+1)'(gha_pkg::MIN_FREE_RESET);

	request_t    request_q[$];
	request_t    batch_q[$];
	outcome_t    outcome_q[$];
	logic        took = 1'b0;
	int unsigned wait_cnt = 0;
	int unsigned n_sent = 0;
	int unsigned n_accepted = 0;
	int unsigned n_checked = 0;
	int unsigned errors = 0;
	int unsigned n_reused = 0;
	int unsigned n_full_create = 0;
	int unsigned n_full_destroy = 0;
	int unsigned n_stale = 0;
	int unsigned n_wraps = 0;
	int unsigned mid_min = 0;

	initial forever #1 clk = ~clk;

	initial begin
		#1_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic request_t mk_request(logic [1:0] f, logic [IDX_W-1:0] i,
			logic [GEN_W-1:0] g);
		request_t r;
		r.func = f;
		r.idx  = i;
		r.gen  = g;
		r.gap  = 0;
		return r;
	endfunction

	function automatic logic handle_live(logic [IDX_W-1:0] i, logic [GEN_W-1:0] g);
		if ({1'b0, i} >= next_fresh)
			return 1'b0;
		return gen_mem[i] == g;
	endfunction

	// advance the predicted state by one request and return its result
	function automatic outcome_t apply_request(request_t rq);
		outcome_t r;
		r.status = gha_pkg::ST_OK;
		r.alive  = 1'b0;
		r.idx    = '0;
		r.gen    = '0;
		case (rq.func)
			gha_pkg::FUNC_CREATE: begin
				if (ring_count > reuse_min) begin
					r.idx = free_ring[ring_head];
					r.gen = gen_mem[r.idx];
					ring_head++;
					ring_count--;
					n_reused++;
				end else if (next_fresh < SLOTS) begin
					r.idx = next_fresh[IDX_W-1:0];
					gen_mem[r.idx] = '0;
					next_fresh++;
				end else begin
					r.status = gha_pkg::ST_FULL;
					n_full_create++;
				end
			end
			gha_pkg::FUNC_DESTROY: begin
				if (!handle_live(rq.idx, rq.gen)) begin
					r.status = gha_pkg::ST_STALE;
					n_stale++;
				end else if (ring_count >= SLOTS) begin
					r.status = gha_pkg::ST_FULL;
					n_full_destroy++;
				end else begin
					if (gen_mem[rq.idx] == '1)
						n_wraps++;
					gen_mem[rq.idx]++;
					free_ring[ring_tail] = rq.idx;
					ring_tail++;
					ring_count++;
				end
			end
			gha_pkg::FUNC_QUERY: r.alive = handle_live(rq.idx, rq.gen);
			default: ;
		endcase
		return r;
	endfunction

	// a handle that is currently alive; needs at least one allocated index
	function automatic request_t live_request(logic [1:0] f);
		logic [IDX_W-1:0] i;
		i = IDX_W'($urandom_range(next_fresh - 1, 0));
		return mk_request(f, i, gen_mem[i]);
	endfunction

	function automatic request_t draw_request();
		int unsigned      roll;
		logic [IDX_W-1:0] i;
		logic [GEN_W-1:0] g;
		roll = $urandom_range(99);
		i = IDX_W'($urandom_range(SLOTS - 1, 0));
		g = GEN_W'($urandom_range((1 << GEN_W) - 1, 0));
		if (roll < 35)
			return mk_request(gha_pkg::FUNC_CREATE, i, g);
		if (roll < 60 && next_fresh > 0)
			return live_request(gha_pkg::FUNC_DESTROY);
		if (roll < 75 && next_fresh > 0)
			return live_request(gha_pkg::FUNC_QUERY);
		if (roll < 95) begin
			// near miss on a known index, otherwise plain noise
			if ({1'b0, i} < next_fresh && $urandom_range(1))
				g = $urandom_range(1) ? gen_mem[i] + 1'b1 : gen_mem[i] - 1'b1;
			return mk_request($urandom_range(1) ? gha_pkg::FUNC_QUERY :
				gha_pkg::FUNC_DESTROY, i, g);
		end
		return mk_request(FUNC_NOP, i, g);
	endfunction

	// append one request to the batch under construction
	task automatic stage(request_t r);
		batch_q = {batch_q, r};
	endtask

	task automatic add(logic [1:0] f, logic [IDX_W-1:0] i, logic [GEN_W-1:0] g);
		stage(mk_request(f, i, g));
	endtask

	// hand the batch to the driver; a quarter of batches run back to back
	task automatic push_batch();
		bit no_gaps;
		no_gaps = ($urandom_range(3) == 0);
		@(posedge clk);
		foreach (batch_q[k]) begin
			batch_q[k].gap = no_gaps ? 0 : $urandom_range(11, 0);
			request_q = {request_q, batch_q[k]};
		end
		n_sent += batch_q.size();
		batch_q.delete();
	endtask

	// wait until every request has been taken and every result has come back
	task automatic drain();
		do
			@(negedge clk);
		while (n_accepted != n_sent || outcome_q.size() != 0);
	endtask

	task automatic set_reuse_min(logic [IDX_W:0] v);
		drain();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic mix_phase(int n);
		int               left;
		int               len;
		logic [IDX_W-1:0] h;
		logic [GEN_W-1:0] g;
		left = n;
		while (left > 0) begin
			drain();
			if (next_fresh > 0 && $urandom_range(99) < 12) begin
				// hammer one index with a run of well-formed destroys
				h = (next_fresh > 5) ? IDX_W'(5) : '0;
				g = gen_mem[h];
				len = $urandom_range(24, 12);
				for (int k = 0; k < len; k++)
					add(gha_pkg::FUNC_DESTROY, h, g + k[GEN_W-1:0]);
			end else begin
				len = $urandom_range(12, 1);
				repeat (len)
					stage(draw_request());
			end
			left -= len;
			push_batch();
		end
	endtask

	always @(negedge clk) begin : driver
		request_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || took) begin
			if (request_q.size() == 0) begin
				start <= 1'b0;
			end else if (wait_cnt < request_q[0].gap) begin
				start <= 1'b0;
				wait_cnt++;
			end else begin
				nxt = request_q.pop_front();
				start <= 1'b1;
				func <= nxt.func;
				handle_index <= nxt.idx;
				handle_generation <= nxt.gen;
				wait_cnt = 0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		outcome_t want;
		if (!arst_n) begin
			ring_head = '0;
			ring_tail = '0;
			ring_count = '0;
			next_fresh = '0;
			reuse_min = (IDX_W+1)'(gha_pkg::MIN_FREE_RESET);
			took <= 1'b0;
		end else begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: result with nothing outstanding, status %0d",
							$time, status);
				end else begin
					want = outcome_q.pop_front();
					n_checked++;
					if (status !== want.status || is_alive !== want.alive ||
							out_index !== want.idx || out_generation !== want.gen) begin
						errors++;
						if (errors <= MAX_REPORTS) begin
							$display("%0t: result %0d: expected st %0d alive %0d idx %0d gen %0d",
								$time, n_checked, want.status, want.alive, want.idx,
								want.gen);
							$display("%0t: result %0d: got st %0d alive %0d idx %0d gen %0d",
								$time, n_checked, status, is_alive, out_index,
								out_generation);
						end
					end
				end
			end
			if (start && !busy) begin
				outcome_q = {outcome_q, apply_request(mk_request(func, handle_index,
					handle_generation))};
				n_accepted++;
			end
			if (cfg_we)
				reuse_min = cfg_wdata;
			took <= start && !busy;
		end
	end

	initial begin : stimulus
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: never-allocated, stale, double destroy, unused code
		add(gha_pkg::FUNC_QUERY, 0, 0);
		add(gha_pkg::FUNC_DESTROY, 0, 0);
		add(gha_pkg::FUNC_CREATE, '1, '1);
		add(gha_pkg::FUNC_CREATE, 0, 0);
		add(gha_pkg::FUNC_QUERY, 0, 0);
		add(gha_pkg::FUNC_QUERY, 0, 8'hFF);
		add(gha_pkg::FUNC_DESTROY, 0, 8'hFF);
		add(gha_pkg::FUNC_DESTROY, 0, 0);
		add(gha_pkg::FUNC_QUERY, 0, 0);
		add(gha_pkg::FUNC_QUERY, 0, 1);
		add(gha_pkg::FUNC_DESTROY, 10'h3FF, 8'hFF);
		add(gha_pkg::FUNC_QUERY, 10'h3FF, 8'hFF);
		add(FUNC_NOP, 10'h3FF, 8'hFF);
		add(FUNC_NOP, 0, 0);
		add(gha_pkg::FUNC_CREATE, 0, 0);
		add(gha_pkg::FUNC_DESTROY, 0, 1);
		add(gha_pkg::FUNC_DESTROY, 2, 0);
		add(gha_pkg::FUNC_CREATE, 10'h155, 8'hAA);
		add(gha_pkg::FUNC_QUERY, 3, 0);
		add(gha_pkg::FUNC_DESTROY, 1, 0);
		add(gha_pkg::FUNC_QUERY, 1, 0);
		push_batch();

		set_reuse_min('0);
		mix_phase(250);
		set_reuse_min((IDX_W+1)'(1));
		mix_phase(200);
		mid_min = $urandom_range(40, 2);
		set_reuse_min(mid_min[IDX_W:0]);
		mix_phase(200);
		set_reuse_min((IDX_W+1)'(SLOTS - 1));
		mix_phase(240);

		// exhaust fresh indices, then fill the free queue to the brim
		set_reuse_min((IDX_W+1)'(SLOTS));
		drain();
		while (next_fresh < SLOTS) begin
			repeat ($urandom_range(16, 1))
				stage(($urandom_range(99) < 85) ?
					mk_request(gha_pkg::FUNC_CREATE,
						IDX_W'($urandom_range(SLOTS - 1, 0)), '0) :
					draw_request());
			push_batch();
			drain();
		end
		add(gha_pkg::FUNC_CREATE, 0, 0);
		add(gha_pkg::FUNC_CREATE, 0, 0);
		stage(live_request(gha_pkg::FUNC_QUERY));
		add(gha_pkg::FUNC_CREATE, 0, 0);
		push_batch();
		drain();
		while (ring_count < SLOTS) begin
			repeat ($urandom_range(16, 1))
				stage(live_request(($urandom_range(99) < 90) ?
					gha_pkg::FUNC_DESTROY : gha_pkg::FUNC_QUERY));
			push_batch();
			drain();
		end
		repeat (3)
			stage(live_request(gha_pkg::FUNC_DESTROY));
		add(gha_pkg::FUNC_CREATE, 0, 0);
		push_batch();

		set_reuse_min('0);
		mix_phase(60);

		drain();
		repeat (8) @(posedge clk);
		$display("%0d requests, %0d results checked; thresholds 64, 0, 1, %0d, %0d, %0d, 0",
			n_accepted, n_checked, mid_min, SLOTS - 1, SLOTS);
		$display("%0d reused, %0d full on create, %0d full on destroy, %0d stale, %0d wraps",
			n_reused, n_full_create, n_full_destroy, n_stale, n_wraps);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/gha_pkg.sv
hw/rtl/gha_ctrl.sv
hw/rtl/gha_dpath.sv
hw/rtl/generational_handle_allocator_core.sv
test/tb.sv
